FILE: rtl/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

  localparam int SEQ_W = 8;
  localparam int LEN_W = 16;
  localparam int WIN_W = 6;
  localparam int CFG_IDX_W = 2;

  // event codes on in_mode
  localparam logic [1:0] MODE_DATA    = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_ENABLED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd2;

  localparam logic FRAME_DATA = 1'b0;
  localparam logic FRAME_ACK  = 1'b1;

  localparam logic [LEN_W-1:0] ACK_LENGTH = 16'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = 6'd8;
  localparam logic [LEN_W-1:0] PAYLOAD_RESET = 16'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEND
  } gbn_state_t;

  typedef struct packed {
    logic latch_in;
    logic rx_frame;
    logic ack_apply;
    logic timeout_apply;
    logic push_data;
  } gbn_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       ack_valid;
    logic       credit;
    logic       last;
    logic       out_free;
  } gbn_sts_t;

endpackage

`default_nettype wire

FILE: rtl/gbn_ctrl.sv
`default_nettype none

module gbn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t      cmd
);

  import gbn_pkg::*;

  gbn_state_t state_r;
  gbn_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.mode)
          MODE_DATA:    if (sts.out_free) state_nxt = ST_IDLE;
          MODE_ACK:     state_nxt = sts.ack_valid ? ST_SEND : ST_IDLE;
          MODE_TIMEOUT: state_nxt = ST_SEND;
          default:      state_nxt = ST_IDLE;
        endcase
      end
      ST_SEND: begin
        // leave once the window is used up or the last frame is loaded
        if (!sts.credit) state_nxt = ST_IDLE;
        else if (sts.out_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ST_DECODE: begin
        unique case (sts.mode)
          MODE_DATA:    cmd.rx_frame = sts.out_free;
          MODE_ACK:     cmd.ack_apply = sts.ack_valid;
          MODE_TIMEOUT: cmd.timeout_apply = 1'b1;
          default:      cmd = '0;
        endcase
      end
      ST_SEND: begin
        cmd.push_data = sts.credit && sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/gbn_dp.sv
`default_nettype none

module gbn_dp #(
  parameter int SEQ_MOD = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gbn_pkg::LEN_W-1:0]       cfg_wdata,
  input  wire logic [1:0]                      in_mode,
  input  wire logic [gbn_pkg::SEQ_W-1:0]       in_seq_in,
  input  wire gbn_pkg::gbn_cmd_t               cmd,
  output gbn_pkg::gbn_sts_t                    sts,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_frame_kind,
  output logic [gbn_pkg::SEQ_W-1:0]            out_frame_seq,
  output logic [gbn_pkg::LEN_W-1:0]            out_frame_length,
  output logic                                 out_timer_start,
  output logic                                 out_timer_cancel,
  output logic                                 out_last
);

  import gbn_pkg::*;

  localparam logic [SEQ_W:0]   SEQ_MOD9 = (SEQ_W+1)'(SEQ_MOD);
  localparam logic [SEQ_W:0]   MAX_WIN  = (SEQ_W+1)'(SEQ_MOD - 1);
  localparam logic [2*SEQ_W-1:0] SEQ_MOD16 = (2*SEQ_W)'(SEQ_MOD);

  // reduce an 8-bit number modulo SEQ_MOD by shifted compare/subtract
  function automatic logic [SEQ_W-1:0] seq_reduce(input logic [SEQ_W-1:0] v);
    logic [2*SEQ_W-1:0] acc;
    acc = {{SEQ_W{1'b0}}, v};
    for (int k = SEQ_W - 1; k >= 0; k--) begin
      if (acc >= (SEQ_MOD16 << k)) acc = acc - (SEQ_MOD16 << k);
    end
    return acc[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] dist_of(input logic [SEQ_W-1:0] v,
                                               input logic [SEQ_W-1:0] base);
    logic [SEQ_W:0] d;
    d = {1'b0, v} + SEQ_MOD9 - {1'b0, base};
    if (d >= SEQ_MOD9) d = d - SEQ_MOD9;
    return d[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] v);
    logic [SEQ_W:0] s;
    s = {1'b0, v} + 1'b1;
    if (s == SEQ_MOD9) s = '0;
    return s[SEQ_W-1:0];
  endfunction

  // configuration
  logic [WIN_W-1:0] window_size_r;
  logic             timer_enabled_r;
  logic [LEN_W-1:0] payload_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r    <= WINDOW_RESET;
      timer_enabled_r  <= 1'b1;
      payload_length_r <= PAYLOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:    window_size_r    <= cfg_wdata[WIN_W-1:0];
        CFG_TIMER_ENABLED:  timer_enabled_r  <= cfg_wdata[0];
        CFG_PAYLOAD_LENGTH: payload_length_r <= cfg_wdata;
        default:            window_size_r    <= window_size_r;
      endcase
    end
  end

  // protocol state and the latched event
  logic [SEQ_W-1:0] send_base_r,   send_base_nxt;
  logic [SEQ_W-1:0] next_send_r,   next_send_nxt;
  logic [SEQ_W-1:0] expected_rx_r, expected_rx_nxt;
  logic             timer_running_r, timer_running_nxt;
  logic             cancel_pend_r,   cancel_pend_nxt;
  logic [1:0]       mode_r;
  logic [SEQ_W-1:0] seq_r;

  logic [SEQ_W-1:0] dist_next;
  logic [WIN_W-1:0] win;
  logic             start_now;

  always_comb begin
    dist_next = dist_of(next_send_r, send_base_r);
    win = ({{(SEQ_W+1-WIN_W){1'b0}}, window_size_r} > MAX_WIN) ?
          MAX_WIN[WIN_W-1:0] : window_size_r;
    start_now = timer_enabled_r && !timer_running_r;

    sts.mode      = mode_r;
    sts.ack_valid = (seq_r != send_base_r) &&
                    (dist_next >= dist_of(seq_r, send_base_r));
    sts.credit    = {{(SEQ_W-WIN_W){1'b0}}, win} > dist_next;
    // the frame now at next_send is the last one if it fills the window
    sts.last      = ({1'b0, dist_next} + 1'b1) ==
                    {{(SEQ_W+1-WIN_W){1'b0}}, win};
    sts.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    send_base_nxt     = send_base_r;
    next_send_nxt     = next_send_r;
    expected_rx_nxt   = expected_rx_r;
    timer_running_nxt = timer_running_r;
    cancel_pend_nxt   = cancel_pend_r;
    priority if (cmd.latch_in) begin
      cancel_pend_nxt = 1'b0;
    end else if (cmd.rx_frame) begin
      if (seq_r == expected_rx_r) expected_rx_nxt = seq_inc(expected_rx_r);
    end else if (cmd.ack_apply) begin
      timer_running_nxt = 1'b0;
      send_base_nxt     = seq_r;
      cancel_pend_nxt   = 1'b1;
    end else if (cmd.timeout_apply) begin
      timer_running_nxt = 1'b0;
      next_send_nxt     = send_base_r;
      cancel_pend_nxt   = 1'b0;
    end else if (cmd.push_data) begin
      next_send_nxt     = seq_inc(next_send_r);
      timer_running_nxt = timer_running_r || timer_enabled_r;
      cancel_pend_nxt   = 1'b0;
    end else begin
      cancel_pend_nxt = cancel_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_base_r     <= '0;
      next_send_r     <= '0;
      expected_rx_r   <= '0;
      timer_running_r <= 1'b0;
      cancel_pend_r   <= 1'b0;
    end else begin
      send_base_r     <= send_base_nxt;
      next_send_r     <= next_send_nxt;
      expected_rx_r   <= expected_rx_nxt;
      timer_running_r <= timer_running_nxt;
      cancel_pend_r   <= cancel_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_r <= in_mode;
      seq_r  <= seq_reduce(in_seq_in);
    end
  end

  // output word register
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.rx_frame || cmd.push_data) out_valid_nxt = 1'b1;
    else if (out_ready)                out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_frame) begin
      out_frame_kind   <= FRAME_ACK;
      out_frame_seq    <= (seq_r == expected_rx_r) ? seq_inc(expected_rx_r) : expected_rx_r;
      out_frame_length <= ACK_LENGTH;
      out_timer_start  <= 1'b0;
      out_timer_cancel <= 1'b0;
      out_last         <= 1'b1;
    end else if (cmd.push_data) begin
      out_frame_kind   <= FRAME_DATA;
      out_frame_seq    <= next_send_r;
      out_frame_length <= payload_length_r;
      out_timer_start  <= start_now;
      out_timer_cancel <= cancel_pend_r;
      out_last         <= sts.last;
    end
  end

  assign out_valid = out_valid_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rx_frame || cmd.push_data) |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before it was taken");

  a_seq_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, send_base_r} < SEQ_MOD9) && ({1'b0, next_send_r} < SEQ_MOD9) &&
    ({1'b0, expected_rx_r} < SEQ_MOD9))
    else $error("sequence state out of range");

  a_timer_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_data && timer_enabled_r) |=> timer_running_r)
    else $error("timer not running after a data frame");

  a_ack_cancels: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ack_apply |=> (!timer_running_r && cancel_pend_r))
    else $error("valid ACK did not cancel the timer");

endmodule

`default_nettype wire

FILE: rtl/go_back_n_link_endpoint.sv
// Go-Back-N endpoint: one event word in, zero or more frame words out.
// A data event is latched, decoded, and its ACK word is registered onto out_valid;
// a valid ACK or timeout is latched, decoded, and its data words go out from ST_SEND.
// Data frames go out one per cycle while the output is not stalled; in_ready is low
// until an event is done, so the next event is accepted only back in ST_IDLE.
// Sync reset: sequence state and timer cleared; window 8, timer enabled, payload 1024.
`default_nettype none

module go_back_n_link_endpoint #(
  parameter int SEQ_MOD = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gbn_pkg::LEN_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [gbn_pkg::SEQ_W-1:0]     in_seq_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_frame_kind,
  output logic [gbn_pkg::SEQ_W-1:0]          out_frame_seq,
  output logic [gbn_pkg::LEN_W-1:0]          out_frame_length,
  output logic                               out_timer_start,
  output logic                               out_timer_cancel,
  output logic                               out_last
);

  import gbn_pkg::*;

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbn_dp #(
    .SEQ_MOD (SEQ_MOD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_seq_in        (in_seq_in),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_kind   (out_frame_kind),
    .out_frame_seq    (out_frame_seq),
    .out_frame_length (out_frame_length),
    .out_timer_start  (out_timer_start),
    .out_timer_cancel (out_timer_cancel),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

FILE: dv/go_back_n_link_endpoint_test.sv
`timescale 1ns / 1ps

module go_back_n_link_endpoint_test;
  import gbn_pkg::*;

  // sequence offsets below rely on 8-bit wrap, so SEQ_MOD stays at 256
  localparam int SEQ_MOD = 256;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_EVENTS = 60;
  localparam int MAX_BURST = 63;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] length;
    logic             timer_start;
    logic             timer_cancel;
    logic             last;
  } frame_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_mode = MODE_DATA;
  logic [SEQ_W-1:0]     in_seq_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_frame_kind;
  logic [SEQ_W-1:0]     out_frame_seq;
  logic [LEN_W-1:0]     out_frame_length;
  logic                 out_timer_start;
  logic                 out_timer_cancel;
  logic                 out_last;

  // link state as the block should hold it
  logic [SEQ_W-1:0] tx_base = '0;
  logic [SEQ_W-1:0] tx_next = '0;
  logic [SEQ_W-1:0] rx_expected = '0;
  logic             timer_busy = 1'b0;
  logic [WIN_W-1:0] win_cfg = WINDOW_RESET;
  logic             timer_en_cfg = 1'b1;
  logic [LEN_W-1:0] payload_cfg = PAYLOAD_RESET;

  frame_t frames_due[$];
  int     mismatches = 0;
  int     cycle_count = 0;
  int     stall_left = 0;
  bit     tx_steady = 1'b0;
  bit     rx_steady = 1'b0;

  go_back_n_link_endpoint #(.SEQ_MOD(SEQ_MOD)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_seq_in        (in_seq_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_kind   (out_frame_kind),
    .out_frame_seq    (out_frame_seq),
    .out_frame_length (out_frame_length),
    .out_timer_start  (out_timer_start),
    .out_timer_cancel (out_timer_cancel),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 5);
    return $urandom_range(10, 20);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_steady || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= idle_len() - 1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_frames
    frame_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        report_mismatch("frame word with none due, frame_seq", out_frame_seq, 0);
      end else begin
        want = frames_due.pop_front();
        if (out_frame_kind !== want.kind)
          report_mismatch("frame_kind", out_frame_kind, want.kind);
        if (out_frame_seq !== want.seq)
          report_mismatch("frame_seq", out_frame_seq, want.seq);
        if (out_frame_length !== want.length)
          report_mismatch("frame_length", out_frame_length, want.length);
        if (out_timer_start !== want.timer_start)
          report_mismatch("timer_start", out_timer_start, want.timer_start);
        if (out_timer_cancel !== want.timer_cancel)
          report_mismatch("timer_cancel", out_timer_cancel, want.timer_cancel);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  function automatic logic [SEQ_W-1:0] base_offset(input logic [SEQ_W-1:0] v);
    return v - tx_base;
  endfunction

  // sends every data frame that still has window credit
  task automatic queue_window(input logic cancel_first);
    frame_t f;
    int     n;
    n = 0;
    while (base_offset(tx_next) < win_cfg && n < MAX_BURST) begin
      f.kind         = FRAME_DATA;
      f.seq          = tx_next;
      f.length       = payload_cfg;
      f.timer_start  = timer_en_cfg && !timer_busy;
      f.timer_cancel = (n == 0) ? cancel_first : 1'b0;
      f.last         = 1'b0;
      if (f.timer_start) timer_busy = 1'b1;
      frames_due.push_back(f);
      tx_next = tx_next + 1'b1;
      n++;
    end
    if (n > 0) begin
      f = frames_due.pop_back();
      f.last = 1'b1;
      frames_due.push_back(f);
    end
  endtask

  task automatic predict_event(input logic [1:0] mode, input logic [SEQ_W-1:0] seq);
    frame_t ack;
    case (mode)
      MODE_DATA: begin
        if (seq == rx_expected) rx_expected = rx_expected + 1'b1;
        ack.kind         = FRAME_ACK;
        ack.seq          = rx_expected;
        ack.length       = ACK_LENGTH;
        ack.timer_start  = 1'b0;
        ack.timer_cancel = 1'b0;
        ack.last         = 1'b1;
        frames_due.push_back(ack);
      end
      MODE_ACK: begin
        // ignored unless it moves the base and stays within what was sent
        if (seq != tx_base && base_offset(tx_next) >= base_offset(seq)) begin
          timer_busy = 1'b0;
          tx_base    = seq;
          queue_window(1'b1);
        end
      end
      MODE_TIMEOUT: begin
        timer_busy = 1'b0;
        tx_next    = tx_base;
        queue_window(1'b0);
      end
      default: begin
      end
    endcase
  endtask

  // valid stays high across back-to-back words; lowered for a gap or by wait_idle
  task automatic send_event(input logic [1:0] mode, input logic [SEQ_W-1:0] seq);
    int gap;
    gap = (!tx_steady && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_seq_in <= seq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_event(mode, seq);
  endtask

  // an ignored event leaves nothing to wait on, hence the settle time
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_config(input logic [WIN_W-1:0] win, input logic timer_en,
                              input logic [LEN_W-1:0] payload);
    cfg_put(CFG_WINDOW_SIZE, LEN_W'(win));
    cfg_put(CFG_TIMER_ENABLED, LEN_W'(timer_en));
    cfg_put(CFG_PAYLOAD_LENGTH, payload);
    cfg_we       <= 1'b0;
    win_cfg      = win;
    timer_en_cfg = timer_en;
    payload_cfg  = payload;
  endtask

  task automatic test_receiver();
    send_event(MODE_DATA, 8'd0);
    send_event(MODE_DATA, 8'd0);     // duplicate
    send_event(MODE_DATA, 8'd7);     // out of order
    send_event(MODE_DATA, 8'd1);
    send_event(MODE_DATA, 8'hFF);
  endtask

  task automatic test_sender_defaults();
    send_event(MODE_TIMEOUT, 8'h00); // timer idle, full window goes out
    send_event(MODE_ACK, tx_base);   // ack of the base: ignored
    send_event(MODE_ACK, tx_next + 8'd1);
    send_event(MODE_ACK, tx_base + 8'd3);
    send_event(MODE_TIMEOUT, 8'hA5);
    send_event(MODE_ACK, tx_next);
    send_event(MODE_UNUSED, 8'h5A);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_config(6'd63, 1'b0, 16'hFFFF);
    send_event(MODE_TIMEOUT, 8'hFF);
    send_event(MODE_ACK, tx_next);
    wait_idle();
    write_config(6'd0, 1'b1, 16'h0000);
    send_event(MODE_TIMEOUT, 8'h00); // no credit, no words
    send_event(MODE_ACK, tx_base + 8'd1); // ack past what was sent: ignored
    wait_idle();
    write_config(6'd1, 1'b1, 16'h0000);
    send_event(MODE_TIMEOUT, 8'h00);
    send_event(MODE_ACK, tx_base + 8'd1);
    send_event(MODE_DATA, 8'h80);
  endtask

  task automatic test_random_traffic();
    logic [WIN_W-1:0] win;
    logic [LEN_W-1:0] payload;
    logic [SEQ_W-1:0] span;
    logic [SEQ_W-1:0] seq;
    logic [1:0]       mode;
    int               r;
    int               sent;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin win = 6'd63; payload = 16'hFFFF; end
        1: begin win = 6'd1;  payload = 16'h0000; end
        default: begin
          win = ($urandom_range(0, 9) == 0) ? 6'd0 : WIN_W'($urandom_range(2, 62));
          payload = LEN_W'($urandom_range(0, 65535));
        end
      endcase
      write_config(win, (phase % 3) != 1, payload);
      tx_steady = (phase == 2);
      rx_steady = (phase == 3);
      sent = 0;
      while (sent < PHASE_EVENTS) begin
        r    = $urandom_range(0, 99);
        seq  = SEQ_W'($urandom_range(0, 255));
        span = tx_next - tx_base;
        if (r < 38) begin
          mode = MODE_DATA;
          if ($urandom_range(0, 99) < 80) seq = rx_expected;
        end else if (r < 73) begin
          mode = MODE_ACK;
          if (span != 0 && $urandom_range(0, 99) < 85)
            seq = tx_base + SEQ_W'($urandom_range(1, span));
          else if ($urandom_range(0, 3) == 0)
            seq = tx_base;
        end else if (r < 95) begin
          mode = MODE_TIMEOUT;
        end else begin
          mode = MODE_UNUSED;
        end
        send_event(mode, seq);
        if (mode != MODE_UNUSED) sent++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_receiver();
    test_sender_defaults();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
